// ----- sv/sfd_pkg.sv -----
`timescale 1ns / 1ps

package sfd_pkg;

	localparam int unsigned MaxPayload = 512;

	localparam logic [7:0]  SYNC_FIRST  = 8'hFA;
	localparam logic [7:0]  SYNC_SECOND = 8'hCE;
	localparam logic [15:0] CODE_MASK   = 16'h7FFF;

	localparam logic [15:0] MAX_DATA_LEN  = 16'(MaxPayload);
	localparam logic [15:0] MAX_FRAME_LEN = 16'(MaxPayload + 4);

	// counters never exceed MaxPayload + 4
	localparam int unsigned CntW = $clog2(MaxPayload + 5);

	// header bytes counted after the packet length field
	localparam logic [CntW-1:0] HDR_BYTES = CntW'(4);

	typedef enum logic [3:0] {
		PH_HUNT    = 4'd0,
		PH_SYNC2   = 4'd1,
		PH_FLEN_HI = 4'd2,
		PH_FLEN_LO = 4'd3,
		PH_CMD_HI  = 4'd4,
		PH_CMD_LO  = 4'd5,
		PH_DLEN_HI = 4'd6,
		PH_DLEN_LO = 4'd7,
		PH_DATA    = 4'd8,
		PH_CHECK   = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CSUM    = 2'd1,
		ST_LEN_ERR = 2'd2
	} status_t;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [8:0]  pos;
		logic [14:0] cmd_code;
		logic        is_resp;
		logic [9:0]  plen;
		logic [1:0]  status;
	} result_t;

endpackage

// ----- sv/sfd_parser.sv -----
`timescale 1ns / 1ps

module sfd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	input  logic                take,
	output logic                res_valid,
	output sfd_pkg::result_t    res
);

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    fire;

	sfd_pkg::phase_t         phase_q, phase_d;
	logic [7:0]              sum_q, sum_d;
	logic [15:0]             flen_q, flen_d;
	logic [sfd_pkg::CntW-1:0] fcnt_q, fcnt_d;
	logic [15:0]             cmd_q, cmd_d;
	logic [15:0]             dlen_q, dlen_d;
	logic [sfd_pkg::CntW-1:0] dcnt_q, dcnt_d;

	logic [15:0]             flen_full, dlen_full;
	logic [sfd_pkg::CntW-1:0] fcnt_inc, dcnt_inc;

	assign fire     = valid_s1 && take;
	assign in_ready = !valid_s1 || take;

	// input word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	assign flen_full = {flen_q[15:8], byte_s1};
	assign dlen_full = {dlen_q[15:8], byte_s1};
	assign fcnt_inc  = fcnt_q + 1'b1;
	assign dcnt_inc  = dcnt_q + 1'b1;

	// next state
	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q + byte_s1;
		flen_d  = flen_q;
		fcnt_d  = fcnt_q;
		cmd_d   = cmd_q;
		dlen_d  = dlen_q;
		dcnt_d  = dcnt_q;
		case (phase_q)
			sfd_pkg::PH_HUNT: begin
				sum_d = byte_s1;
				if (byte_s1 == sfd_pkg::SYNC_FIRST) begin
					phase_d = sfd_pkg::PH_SYNC2;
				end
			end
			sfd_pkg::PH_SYNC2: begin
				if (byte_s1 == sfd_pkg::SYNC_SECOND) begin
					phase_d = sfd_pkg::PH_FLEN_HI;
				end
			end
			sfd_pkg::PH_FLEN_HI: begin
				flen_d  = {byte_s1, 8'h00};
				phase_d = sfd_pkg::PH_FLEN_LO;
			end
			sfd_pkg::PH_FLEN_LO: begin
				flen_d  = flen_full;
				fcnt_d  = '0;
				phase_d = (flen_full <= sfd_pkg::MAX_FRAME_LEN) ? sfd_pkg::PH_CMD_HI
					: sfd_pkg::PH_HUNT;
			end
			sfd_pkg::PH_CMD_HI: begin
				cmd_d   = {byte_s1, 8'h00};
				fcnt_d  = fcnt_inc;
				phase_d = sfd_pkg::PH_CMD_LO;
			end
			sfd_pkg::PH_CMD_LO: begin
				cmd_d   = {cmd_q[15:8], byte_s1};
				fcnt_d  = fcnt_inc;
				phase_d = sfd_pkg::PH_DLEN_HI;
			end
			sfd_pkg::PH_DLEN_HI: begin
				dlen_d  = {byte_s1, 8'h00};
				fcnt_d  = fcnt_inc;
				phase_d = sfd_pkg::PH_DLEN_LO;
			end
			sfd_pkg::PH_DLEN_LO: begin
				dlen_d = dlen_full;
				dcnt_d = '0;
				fcnt_d = fcnt_inc;
				if (dlen_full == 16'h0000) begin
					phase_d = sfd_pkg::PH_CHECK;
				end else if ((dlen_full & sfd_pkg::CODE_MASK) <= sfd_pkg::MAX_DATA_LEN) begin
					phase_d = sfd_pkg::PH_DATA;
				end else begin
					phase_d = sfd_pkg::PH_HUNT;
				end
			end
			sfd_pkg::PH_DATA: begin
				dcnt_d = dcnt_inc;
				fcnt_d = fcnt_inc;
				if (16'(dcnt_inc) >= dlen_q || 16'(fcnt_inc) >= flen_q) begin
					phase_d = sfd_pkg::PH_CHECK;
				end
			end
			sfd_pkg::PH_CHECK: begin
				sum_d   = sum_q;
				phase_d = sfd_pkg::PH_HUNT;
			end
			default: begin
				sum_d   = sum_q;
				phase_d = sfd_pkg::PH_HUNT;
			end
		endcase
	end

	// result word
	always_comb begin
		res_valid    = 1'b0;
		res.kind     = sfd_pkg::KIND_DATA;
		res.data     = byte_s1;
		res.pos      = dcnt_q[8:0];
		res.cmd_code = cmd_q[14:0];
		res.is_resp  = cmd_q[15];
		res.plen     = dlen_q[9:0];
		res.status   = sfd_pkg::ST_OK;
		case (phase_q)
			sfd_pkg::PH_DATA: begin
				res_valid = fire;
			end
			sfd_pkg::PH_CHECK: begin
				res_valid = fire;
				res.kind  = sfd_pkg::KIND_END;
				res.data  = '0;
				res.pos   = '0;
				if (sum_q != byte_s1) begin
					res.status = sfd_pkg::ST_CSUM;
				end else if (16'(dcnt_q) != dlen_q || 16'(fcnt_q) != flen_q) begin
					res.status = sfd_pkg::ST_LEN_ERR;
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfd_pkg::PH_HUNT;
			sum_q   <= '0;
			flen_q  <= '0;
			fcnt_q  <= '0;
			cmd_q   <= '0;
			dlen_q  <= '0;
			dcnt_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			flen_q  <= flen_d;
			fcnt_q  <= fcnt_d;
			cmd_q   <= cmd_d;
			dlen_q  <= dlen_d;
			dcnt_q  <= dcnt_d;
		end
	end

	// header is always four bytes ahead of the payload count
	a_cnt_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sfd_pkg::PH_DATA || phase_q == sfd_pkg::PH_CHECK)
		|-> fcnt_q == dcnt_q + sfd_pkg::HDR_BYTES)
		else $error("frame and payload counters out of step");

	a_data_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sfd_pkg::PH_DATA) |-> 16'(dcnt_q) < dlen_q)
		else $error("payload count past declared length");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> take)
		else $error("result produced while output register full");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take |=> valid_s1 && $stable(byte_s1) && $stable(phase_q))
		else $error("stalled word or state changed");

endmodule

// ----- sv/sfd_out_stage.sv -----
`timescale 1ns / 1ps

module sfd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  sfd_pkg::result_t res,
	output logic             take,
	output logic             out_valid,
	input  logic             out_ready,
	output sfd_pkg::result_t res_q
);

	logic out_valid_q;

	assign take      = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			res_q <= res;
		end
	end

endmodule

// ----- sv/serial_frame_deframer_checksum_core.sv -----
`timescale 1ns / 1ps

// Serial frame deframer with additive 8-bit checksum.
// Input channel: in_valid / in_ready carrying rx_byte, one received byte per word.
// Output channel: out_valid / out_ready. A word with out_kind = 0 forwards one
// payload byte (payload_byte, payload_position) as soon as it arrives; a word with
// out_kind = 1 closes a frame and carries frame_status (0 ok, 1 checksum mismatch,
// 2 length mismatch). Command and declared length fields ride on every word.
// Frames that fail the length limits are dropped with no output word.
// A byte that gives an output word passes the input register, then the output register.
// Throughput: one byte per cycle while the receiver takes words. The parser only
// advances when the output register can take a word, so a held output word stops
// every byte, including sync, header and length bytes that give no output.
// Reset clears the parser to sync hunt and empties both registers.
// When the receiver stalls, the output word holds and the input register keeps
// one more byte; in_ready falls only when both are full.
module serial_frame_deframer_checksum_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_kind,
	output logic [7:0]  payload_byte,
	output logic [8:0]  payload_position,
	output logic [14:0] command_code,
	output logic        is_response,
	output logic [9:0]  payload_length,
	output logic [1:0]  frame_status
);

	logic             take;
	logic             res_valid;
	sfd_pkg::result_t res;
	sfd_pkg::result_t res_q;

	sfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	sfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign out_kind         = res_q.kind;
	assign payload_byte     = res_q.data;
	assign payload_position = res_q.pos;
	assign command_code     = res_q.cmd_code;
	assign is_response      = res_q.is_resp;
	assign payload_length   = res_q.plen;
	assign frame_status     = res_q.status;

endmodule
